@@ hw/rtl/tns_pkg.sv @@
// Shared constants, types and codes for the TNS all-pole lattice decode filter.
// No dependencies; imported by tns_mac, tns_all_pole_lattice_filter and the testbench.
`default_nettype none

package tns_pkg;

  localparam int MAX_ORDER = 20;
  localparam int ADDR_W    = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int ORD_W     = $clog2(MAX_ORDER + 1);

  localparam int COEF_W = 16;
  localparam int TAP_W  = 48;
  localparam int SMP_W  = 24;
  localparam int HALF_W = TAP_W / 2;               // tap split for the filter MAC

  localparam int HPROD_W = HALF_W + SMP_W;         // upper half times sample
  localparam int LPROD_W = HALF_W + 1 + SMP_W;     // unsigned lower half times sample
  localparam int HSUM_W  = HPROD_W + ORD_W;
  localparam int LSUM_W  = LPROD_W + ORD_W;

  typedef enum logic [1:0] {
    OP_BEGIN  = 2'd0,
    OP_COEF   = 2'd1,
    OP_SAMPLE = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LD_RD,
    ST_LD_MUL,
    ST_LD_WR1,
    ST_LD_WR2,
    ST_LD_TAIL,
    ST_FL_RUN,
    ST_FL_DRAIN,
    ST_FL_DONE
  } state_t;

  typedef struct packed {
    logic clr;   // zero the accumulators
    logic vld;   // tap and history operands are present
  } mac_ctl_t;

endpackage

`default_nettype wire

@@ hw/rtl/tns_mac.sv @@
// Filter multiply-accumulate: tap split into signed upper and unsigned lower halves.
// Depends on tns_pkg.
`default_nettype none

module tns_mac
  import tns_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire mac_ctl_t                 ctl,
  input  wire logic signed [TAP_W-1:0]  tap,
  input  wire logic signed [SMP_W-1:0]  hist,
  output logic signed [HSUM_W-1:0]      hsum,
  output logic signed [LSUM_W-1:0]      lsum
);

  logic signed [HALF_W-1:0]  tap_hi;
  logic signed [HALF_W:0]    tap_lo;
  logic signed [HPROD_W-1:0] prod_hi_r;
  logic signed [LPROD_W-1:0] prod_lo_r;
  logic                      prod_vld_r;
  logic signed [HSUM_W-1:0]  hsum_r;
  logic signed [LSUM_W-1:0]  lsum_r;

  assign tap_hi = tap[TAP_W-1:HALF_W];
  assign tap_lo = $signed({1'b0, tap[HALF_W-1:0]});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
    end else begin
      prod_vld_r <= ctl.vld;
    end
  end

  always_ff @(posedge clk) begin
    prod_hi_r <= tap_hi * hist;
    prod_lo_r <= tap_lo * hist;
    if (!rst_n || ctl.clr) begin
      hsum_r <= '0;
      lsum_r <= '0;
    end else if (prod_vld_r) begin
      hsum_r <= hsum_r + HSUM_W'(prod_hi_r);
      lsum_r <= lsum_r + LSUM_W'(prod_lo_r);
    end
  end

  assign hsum = hsum_r;
  assign lsum = lsum_r;

`ifndef SYNTHESIS
  a_clr_no_vld : assert property (@(posedge clk) disable iff (!rst_n)
    ctl.clr |-> !ctl.vld)
    else $error("mac clear with operands present");
  a_clr_drained : assert property (@(posedge clk) disable iff (!rst_n)
    ctl.clr |-> !prod_vld_r)
    else $error("mac clear while a product is in flight");
  a_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (!prod_vld_r && !ctl.clr) |=> ($stable(hsum_r) && $stable(lsum_r)))
    else $error("accumulator moved without a product");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/tns_all_pole_lattice_filter.sv @@
// Top level of the TNS all-pole lattice decode filter: sequencer, tap and history
// memories, step-up datapath, output register. Depends on tns_pkg and tns_mac.
`default_nettype none

// Channel  | ports                                          | role
// ---------+------------------------------------------------+---------------------------
// in       | in_valid/in_ready, in_operation,               | begin, coefficient, sample
//          | in_reflection_coef, in_sample_in               |
// out      | out_valid/out_ready, out_sample_out            | one item per sample
//
// Begin is taken while idle. Coefficient at order m: read, multiply and two writes per
// tap pair through the single tap write port, then the tail tap; dropped at full order.
// Sample at order n: one MAC, one tap a cycle, then drain; no MAC pass at order zero.
// Reset (rst_n low, synchronous) empties the predictor and marks all history zero.
// in_ready is high only between items; a finished sample waits in the output register
// while the next item is taken, and stalls only if the previous result is not yet taken.

module tns_all_pole_lattice_filter
  import tns_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [1:0]               in_operation,
  input  wire logic signed [COEF_W-1:0] in_reflection_coef,
  input  wire logic signed [SMP_W-1:0]  in_sample_in,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic signed [SMP_W-1:0]       out_sample_out
);

  localparam int PROD_W = COEF_W + TAP_W;
  localparam int RND_W  = PROD_W - 15;
  localparam int SUM_W  = RND_W + 1;
  localparam int ACC_W  = HSUM_W + 1;
  localparam int DIFF_W = ACC_W + 1;

  localparam logic signed [TAP_W-1:0] TAP_MAX = {1'b0, {(TAP_W-1){1'b1}}};
  localparam logic signed [TAP_W-1:0] TAP_MIN = {1'b1, {(TAP_W-1){1'b0}}};
  localparam logic signed [SMP_W-1:0] SMP_MAX = {1'b0, {(SMP_W-1){1'b1}}};
  localparam logic signed [SMP_W-1:0] SMP_MIN = {1'b1, {(SMP_W-1){1'b0}}};
  localparam logic [ORD_W-1:0] ORD_FULL = ORD_W'(MAX_ORDER);
  localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(MAX_ORDER - 1);

  function automatic logic signed [TAP_W-1:0] sat_tap(input logic signed [SUM_W-1:0] v);
    logic signed [TAP_W-1:0] res;
    if (v > SUM_W'(TAP_MAX))      res = TAP_MAX;
    else if (v < SUM_W'(TAP_MIN)) res = TAP_MIN;
    else                          res = v[TAP_W-1:0];
    return res;
  endfunction

  // ---------------------------------------------------------------- control state
  state_t               state_r, state_nxt;
  logic [ORD_W-1:0]     order_r, order_nxt;
  logic [ADDR_W-1:0]    hptr_r, hptr_nxt;
  logic [ORD_W-1:0]     cnt_r, cnt_nxt;       // pair index on load, tap index on filter
  logic [ADDR_W-1:0]    idx_r, idx_nxt;       // history slot on filter
  logic                 drain_r, drain_nxt;
  logic [MAX_ORDER-1:0] hvld_r, hvld_nxt;     // history slot written since begin
  logic                 rd_vld_r;
  logic                 hist_ok_r;
  logic                 out_valid_r, out_valid_nxt;

  // ---------------------------------------------------------------- payload
  logic signed [COEF_W-1:0] coef_r, coef_nxt;
  logic signed [SMP_W-1:0]  x_r, x_nxt;
  logic signed [TAP_W-1:0]  newb_r, newb_nxt;
  logic signed [SMP_W-1:0]  out_sample_r, out_sample_nxt;

  // ---------------------------------------------------------------- memories
  logic signed [TAP_W-1:0] tap_mem [MAX_ORDER];
  logic signed [SMP_W-1:0] hist_mem [MAX_ORDER];
  logic signed [TAP_W-1:0] tap_a_r, tap_b_r;
  logic signed [SMP_W-1:0] hist_rd_r;

  logic                    tap_we, tap_re;
  logic [ADDR_W-1:0]       tap_wa, tap_ra_a, tap_ra_b;
  logic signed [TAP_W-1:0] tap_wd;
  logic                    hist_we, hist_re;
  logic [ADDR_W-1:0]       hist_wa, hist_ra;
  logic signed [SMP_W-1:0] hist_wd;

  // ---------------------------------------------------------------- datapath
  logic [ORD_W-1:0]         mirror;           // m-1-i
  logic [ORD_W-1:0]         cnt_inc;
  logic signed [PROD_W-1:0] prod_a_r, prod_b_r;
  logic signed [PROD_W-1:0] prod_a_rnd, prod_b_rnd;
  logic signed [SUM_W-1:0]  sum_a, sum_b;
  logic signed [SMP_W-1:0]  hist_op;
  logic signed [TAP_W-1:0]  tail_tap;
  logic [ADDR_W-1:0]        hptr_dec;
  mac_ctl_t                 mac_ctl;
  logic signed [HSUM_W-1:0] hsum;
  logic signed [LSUM_W-1:0] lsum;
  logic signed [LSUM_W-1:0] lsum_rnd;
  logic signed [ACC_W-1:0]  acc;
  logic signed [DIFF_W-1:0] diff;
  logic signed [SMP_W-1:0]  y_sat;
  logic                     out_free;

  assign mirror  = order_r - ORD_W'(1) - cnt_r;
  assign cnt_inc = cnt_r + ORD_W'(1);

  // step-up: new a[i] = a[i] + round(k * a[m-1-i]), and the mirror entry alike
  always_ff @(posedge clk) begin
    prod_a_r <= coef_r * tap_b_r;
    prod_b_r <= coef_r * tap_a_r;
  end

  assign prod_a_rnd = prod_a_r + PROD_W'(16384);
  assign prod_b_rnd = prod_b_r + PROD_W'(16384);
  assign sum_a = SUM_W'(tap_a_r) + SUM_W'($signed(prod_a_rnd[PROD_W-1:15]));
  assign sum_b = SUM_W'(tap_b_r) + SUM_W'($signed(prod_b_rnd[PROD_W-1:15]));
  assign tail_tap = {{(TAP_W-COEF_W-9){coef_r[COEF_W-1]}}, coef_r, 9'b0};

  // never-written history reads as zero
  assign hist_op = hist_ok_r ? hist_rd_r : '0;

  tns_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .tap   (tap_a_r),
    .hist  (hist_op),
    .hsum  (hsum),
    .lsum  (lsum)
  );

  // y = x - round(sum / 2^24); lower-half sum carries the rounding
  assign lsum_rnd = lsum + LSUM_W'(1 << (HALF_W - 1));
  assign acc  = ACC_W'(hsum) + ACC_W'($signed(lsum_rnd[LSUM_W-1:HALF_W]));
  assign diff = DIFF_W'(x_r) - DIFF_W'(acc);
  always_comb begin
    if (diff > DIFF_W'(SMP_MAX))      y_sat = SMP_MAX;
    else if (diff < DIFF_W'(SMP_MIN)) y_sat = SMP_MIN;
    else                              y_sat = diff[SMP_W-1:0];
  end

  assign hptr_dec = (hptr_r == '0) ? ADDR_LAST : hptr_r - ADDR_W'(1);
  assign out_free = !out_valid_r || out_ready;

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_nxt      = state_r;
    order_nxt      = order_r;
    hptr_nxt       = hptr_r;
    cnt_nxt        = cnt_r;
    idx_nxt        = idx_r;
    drain_nxt      = drain_r;
    hvld_nxt       = hvld_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_sample_nxt = out_sample_r;
    coef_nxt       = coef_r;
    x_nxt          = x_r;
    newb_nxt       = newb_r;
    tap_we         = 1'b0;
    tap_wa         = cnt_r[ADDR_W-1:0];
    tap_wd         = sat_tap(sum_a);
    tap_re         = 1'b0;
    tap_ra_a       = cnt_r[ADDR_W-1:0];
    tap_ra_b       = mirror[ADDR_W-1:0];
    hist_we        = 1'b0;
    hist_wa        = hptr_dec;
    hist_wd        = y_sat;
    hist_re        = 1'b0;
    hist_ra        = idx_r;
    mac_ctl.clr    = 1'b0;
    mac_ctl.vld    = rd_vld_r;
    in_ready       = (state_r == ST_IDLE);

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (op_t'(in_operation))
            OP_BEGIN: begin
              order_nxt = '0;
              hptr_nxt  = '0;
              hvld_nxt  = '0;
            end
            OP_COEF: begin
              coef_nxt = in_reflection_coef;
              cnt_nxt  = '0;
              if (order_r == '0) begin
                state_nxt = ST_LD_TAIL;
              end else if (order_r != ORD_FULL) begin
                state_nxt = ST_LD_RD;
              end
            end
            OP_SAMPLE: begin
              x_nxt       = in_sample_in;
              cnt_nxt     = '0;
              idx_nxt     = hptr_r;
              mac_ctl.clr = 1'b1;
              state_nxt   = (order_r == '0) ? ST_FL_DONE : ST_FL_RUN;
            end
            OP_NONE: begin
            end
            default: begin
            end
          endcase
        end
      end
      ST_LD_RD: begin
        tap_re    = 1'b1;
        state_nxt = ST_LD_MUL;
      end
      ST_LD_MUL: begin
        state_nxt = ST_LD_WR1;
      end
      ST_LD_WR1: begin
        tap_we    = 1'b1;
        newb_nxt  = sat_tap(sum_b);
        state_nxt = ST_LD_WR2;
      end
      ST_LD_WR2: begin
        // middle entry of an odd order was written already
        tap_we  = (mirror != cnt_r);
        tap_wa  = mirror[ADDR_W-1:0];
        tap_wd  = newb_r;
        cnt_nxt = cnt_inc;
        if ({cnt_inc, 1'b0} < {1'b0, order_r}) begin
          state_nxt = ST_LD_RD;
        end else begin
          state_nxt = ST_LD_TAIL;
        end
      end
      ST_LD_TAIL: begin
        tap_we    = 1'b1;
        tap_wa    = order_r[ADDR_W-1:0];
        tap_wd    = tail_tap;
        order_nxt = order_r + ORD_W'(1);
        state_nxt = ST_IDLE;
      end
      ST_FL_RUN: begin
        tap_re  = 1'b1;
        hist_re = 1'b1;
        cnt_nxt = cnt_inc;
        idx_nxt = (idx_r == ADDR_LAST) ? '0 : idx_r + ADDR_W'(1);
        if (cnt_inc == order_r) begin
          drain_nxt = 1'b0;
          state_nxt = ST_FL_DRAIN;
        end
      end
      ST_FL_DRAIN: begin
        // operand register, then product register, then accumulator
        drain_nxt = 1'b1;
        if (drain_r) begin
          state_nxt = ST_FL_DONE;
        end
      end
      ST_FL_DONE: begin
        if (out_free) begin
          out_valid_nxt      = 1'b1;
          out_sample_nxt     = y_sat;
          hist_we            = 1'b1;
          hvld_nxt[hptr_dec] = 1'b1;
          hptr_nxt           = hptr_dec;
          state_nxt          = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      order_r     <= '0;
      hptr_r      <= '0;
      cnt_r       <= '0;
      idx_r       <= '0;
      drain_r     <= 1'b0;
      hvld_r      <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      order_r     <= order_nxt;
      hptr_r      <= hptr_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      drain_r     <= drain_nxt;
      hvld_r      <= hvld_nxt;
      rd_vld_r    <= (state_r == ST_FL_RUN);
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    coef_r       <= coef_nxt;
    x_r          <= x_nxt;
    newb_r       <= newb_nxt;
    out_sample_r <= out_sample_nxt;
  end

  // tap memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (tap_we) begin
      tap_mem[tap_wa] <= tap_wd;
    end
    if (tap_re) begin
      tap_a_r <= tap_mem[tap_ra_a];
      tap_b_r <= tap_mem[tap_ra_b];
    end
  end

  // history memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[hist_wa] <= hist_wd;
    end
    if (hist_re) begin
      hist_rd_r <= hist_mem[hist_ra];
      hist_ok_r <= hvld_r[hist_ra];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;

`ifndef SYNTHESIS
  a_order_range : assert property (@(posedge clk) disable iff (!rst_n)
    order_r <= ORD_FULL)
    else $error("filter order beyond maximum");
  a_hptr_range : assert property (@(posedge clk) disable iff (!rst_n)
    ORD_W'(hptr_r) < ORD_FULL)
    else $error("history pointer out of range");
  a_tap_wr_range : assert property (@(posedge clk) disable iff (!rst_n)
    tap_we |-> (ORD_W'(tap_wa) <= order_r))
    else $error("tap write beyond current order");
  a_done_stall : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FL_DONE && out_valid_r && !out_ready)
      |=> (state_r == ST_FL_DONE && out_valid_r && $stable(hptr_r)))
    else $error("finished sample did not wait for the output register");
`endif

endmodule

`default_nettype wire

@@ verif/tb_tns_all_pole_lattice_filter.sv @@
// Self-checking testbench for tns_all_pole_lattice_filter: a bit-exact filter predictor
// in a scoreboard class, directed and random item streams, random idling and back-pressure.
// Depends on tns_pkg and the RTL of the filter; reads no files.

module tb_tns_all_pole_lattice_filter;
  import tns_pkg::*;

  localparam int     CLK_HALF     = 6;
  localparam int     LIMIT_CYCLES = 2_000_000;
  localparam int     HOLD_CYCLES  = 400;      // long receiver hold-off in the pressure phase
  localparam int     TAIL_CYCLES  = 64;       // > worst coefficient or sample time
  localparam int     PHASE_ITEMS  = 205;
  localparam longint TAP_HI       = (64'sd1 <<< (TAP_W - 1)) - 1;
  localparam longint TAP_LO       = -TAP_HI - 1;
  localparam longint SMP_HI       = (64'sd1 <<< (SMP_W - 1)) - 1;
  localparam longint SMP_LO       = -SMP_HI - 1;

  // Predictor and expected-sample store. The taps are Q24 in 48 bits, the history holds
  // past outputs in a circular buffer that is written downward.
  class tns_sample_checker;
    longint taps[MAX_ORDER];
    longint past_out[MAX_ORDER];
    int unsigned order;
    int unsigned newest;
    logic signed [SMP_W-1:0] expected_samples[$];
    int mismatches;

    function new();
      clear_filter();
      mismatches = 0;
    endfunction

    function void clear_filter();
      foreach (taps[i]) begin
        taps[i] = 0;
        past_out[i] = 0;
      end
      order = 0;
      newest = 0;
    endfunction

    function longint sat(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    // Step-up recursion: a[j] += round(k * a[m-1-j]), then the new tap is k in Q24.
    function void step_up(longint k);
      longint next_taps[MAX_ORDER];
      longint prod;
      int unsigned m;
      m = order;
      if (m >= MAX_ORDER) return;    // order full: coefficient dropped
      for (int unsigned j = 0; j < m; j++) begin
        prod = k * taps[m - 1 - j];
        next_taps[j] = sat(taps[j] + ((prod + 64'sd16384) >>> 15), TAP_LO, TAP_HI);
      end
      for (int unsigned j = 0; j < m; j++) taps[j] = next_taps[j];
      taps[m] = k * 512;
      order = m + 1;
    endfunction

    // y = x - sum(a[j] * y[n-1-j]); the sum is split into tap halves, rounded from Q24.
    function logic signed [SMP_W-1:0] predict_filtered_sample(longint x);
      longint hsum, lsum, acc, lo, hi, y;
      int unsigned idx;
      hsum = 0;
      lsum = 0;
      for (int unsigned j = 0; j < order; j++) begin
        lo = taps[j] & 64'sh00FF_FFFF;
        hi = taps[j] >>> 24;
        idx = newest + j;
        if (idx >= MAX_ORDER) idx -= MAX_ORDER;
        hsum += hi * past_out[idx];
        lsum += lo * past_out[idx];
      end
      acc = hsum + ((lsum + 64'sd8388608) >>> 24);
      y = sat(x - acc, SMP_LO, SMP_HI);
      newest = (newest == 0) ? MAX_ORDER - 1 : newest - 1;
      past_out[newest] = y;
      return y[SMP_W-1:0];
    endfunction

    function void note_input(op_t op, logic signed [COEF_W-1:0] k,
                             logic signed [SMP_W-1:0] x);
      case (op)
        OP_BEGIN:  clear_filter();
        OP_COEF:   step_up(k);
        OP_SAMPLE: expected_samples.push_back(predict_filtered_sample(x));
        default: ;
      endcase
    endfunction

    task report_mismatch(string msg);
      if (mismatches < 50) $display("mismatch: %s", msg);
      mismatches++;
    endtask

    task check_result(logic signed [SMP_W-1:0] got);
      logic signed [SMP_W-1:0] want;
      if (expected_samples.size() == 0) begin
        report_mismatch($sformatf("sample_out %0d with nothing expected", got));
      end else begin
        want = expected_samples.pop_front();
        if (got !== want)
          report_mismatch($sformatf("sample_out got %0d want %0d", got, want));
      end
    endtask

    task finish_check();
      if (expected_samples.size() != 0)
        report_mismatch($sformatf("%0d samples never came out", expected_samples.size()));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_operation = OP_NONE;
  logic signed [COEF_W-1:0] in_reflection_coef = '0;
  logic signed [SMP_W-1:0] in_sample_in = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [SMP_W-1:0] out_sample_out;

  tns_sample_checker sb;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic recv_hold = 1'b0;
  logic hold_off_go = 1'b0;
  int unsigned items_sent = 0;

  tns_all_pole_lattice_filter DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_operation       (in_operation),
    .in_reflection_coef (in_reflection_coef),
    .in_sample_in       (in_sample_in),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_sample_out     (out_sample_out)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Receiver: decides out_ready at each falling edge; the hold-off overrides it.
  always @(negedge clk) begin
    out_ready = !recv_hold && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Pressure: once triggered, keep out_ready low for a long stretch so the output
  // register fills and the block stops taking items while the sender keeps offering.
  initial begin
    wait (hold_off_go);
    @(posedge clk);
    recv_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    recv_hold = 1'b0;
  end

  // Result monitor: registered outputs read right after the rising edge hold the
  // values that the edge sampled.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_sample_out);
  end

  // One item: random gap with valid low, then valid high until in_ready at an edge.
  // At most one write to in_valid per falling edge.
  task automatic send_item(op_t op, logic signed [COEF_W-1:0] k, logic signed [SMP_W-1:0] x);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk);
      in_valid = 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_operation = op;
    in_reflection_coef = k;
    in_sample_in = x;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(op, k, x);
    if (op != OP_NONE) items_sent++;
  endtask

  // Mostly modest coefficients so filters stay usable; some near +-1.0 and raw ones.
  function automatic logic signed [COEF_W-1:0] pick_coef();
    int unsigned r;
    int v;
    r = $urandom_range(0, 99);
    if (r < 55) v = int'($urandom_range(0, 8190)) - 4095;
    else if (r < 80) v = int'($urandom_range(0, 32766)) - 16383;
    else if (r < 90) v = $urandom_range(0, 1) ? 32767 : -32768;
    else v = $urandom;
    return v[COEF_W-1:0];
  endfunction

  function automatic logic signed [SMP_W-1:0] pick_sample();
    int unsigned r;
    int v;
    r = $urandom_range(0, 99);
    if (r < 45) v = int'($urandom_range(0, 65534)) - 32767;
    else if (r < 80) v = $urandom;
    else if (r < 90) v = $urandom_range(0, 1) ? 8388607 : -8388608;
    else v = int'($urandom_range(0, 510)) - 255;
    return v[SMP_W-1:0];
  endfunction

  // Well-formed sequence: begin (usually), coefficients, then samples, with the odd
  // coefficient between samples. Some orders run past the maximum; some sample runs
  // are long enough to wrap the history.
  task automatic run_filter_burst();
    int unsigned r, ord, n_smp;
    if ($urandom_range(0, 99) < 80) send_item(OP_BEGIN, COEF_W'($urandom), SMP_W'($urandom));
    r = $urandom_range(0, 99);
    if (r < 50) ord = $urandom_range(0, 6);
    else if (r < 85) ord = $urandom_range(7, MAX_ORDER);
    else ord = $urandom_range(MAX_ORDER + 1, MAX_ORDER + 3);
    for (int unsigned i = 0; i < ord; i++) send_item(OP_COEF, pick_coef(), SMP_W'($urandom));
    n_smp = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
    for (int unsigned i = 0; i < n_smp; i++) begin
      if ($urandom_range(0, 99) < 12) send_item(OP_COEF, pick_coef(), SMP_W'($urandom));
      send_item(OP_SAMPLE, COEF_W'($urandom), pick_sample());
    end
  endtask

  // Noise: any operation code with raw field contents.
  task automatic send_noise();
    repeat ($urandom_range(1, 3))
      send_item(op_t'($urandom_range(0, 3)), COEF_W'($urandom), SMP_W'($urandom));
  endtask

  initial begin
    int unsigned phase_start, guard;
    sb = new();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: zero order passes samples straight through, at both rails.
    send_item(OP_SAMPLE, 16'sd0, 24'sd8388607);
    send_item(OP_SAMPLE, -16'sd1, -24'sd8388608);
    send_item(OP_NONE, -16'sd1, -24'sd1);           // unused code: no effect, no result
    send_item(OP_BEGIN, 16'sd0, 24'sd0);
    send_item(OP_COEF, -16'sd32768, 24'sd0);        // a1 = -1.0: y = x + y_prev
    send_item(OP_SAMPLE, 16'sd0, 24'sd8388607);
    send_item(OP_SAMPLE, 16'sd0, 24'sd8388607);     // saturates high
    send_item(OP_SAMPLE, 16'sd0, -24'sd8388608);
    send_item(OP_COEF, 16'sd32767, 24'sd0);         // coefficient between samples
    send_item(OP_SAMPLE, 16'sd0, -24'sd8388608);
    for (int i = 0; i < MAX_ORDER - 2; i++)
      send_item(OP_COEF, i[0] ? -16'sd3000 : 16'sd2500, 24'sd0);
    send_item(OP_COEF, 16'sd12345, 24'sd0);         // order full: dropped
    send_item(OP_SAMPLE, 16'sd0, 24'sd1000);

    // Random phases: no idling, sender idle, receiver stalling, both, then pressure.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
        3: begin send_idle_pct = 21; recv_stall_pct = 21; end
        default: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
          hold_off_go = 1'b1;
        end
      endcase
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        if ($urandom_range(0, 99) < 85) run_filter_burst();
        else send_noise();
      end
    end
    @(negedge clk);
    in_valid = 1'b0;

    // Drain, then give the block time to show any stray result.
    recv_stall_pct = 0;
    guard = 0;
    while (sb.expected_samples.size() != 0 && guard < 100_000) begin
      @(posedge clk);
      guard++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    sb.finish_check();
    if (sb.mismatches == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #(LIMIT_CYCLES * 2 * CLK_HALF);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
